FILE: rtl/htfd_pkg.sv
// Shared types, constants and the CRC-8 step function for the frame decoder.
package htfd_pkg;

	// Frame kinds. Any kind with bit 1 set is decoded as a register read.
	typedef enum logic [1:0] {
		CMD_HUMID = 2'd0,
		CMD_TEMP  = 2'd1,
		CMD_REG   = 2'd2,
		CMD_SPARE = 2'd3
	} cmd_t;

	localparam int unsigned CmdRegBit = 1;

	// Polynomial x^8+x^5+x^4+1 with the x^8 term implied.
	localparam logic [7:0] CrcPoly = 8'h31;
	localparam logic [1:0] StatusMask = 2'b11;
	localparam int unsigned HeaterBit = 2;
	localparam int unsigned EobBit = 6;

	localparam logic [14:0] RhScale = 15'd12500;
	localparam logic [14:0] TempScale = 15'd17572;
	localparam logic signed [15:0] RhOffset = 16'sd600;
	localparam logic signed [15:0] TempOffset = 16'sd4685;

	typedef struct packed {
		logic       is_reg;
		logic       is_temp;
		logic [7:0] byte_high;
		logic [7:0] byte_low;
		logic [7:0] check_byte;
		logic [7:0] crc;
	} s1_t;

	typedef struct packed {
		logic        is_reg;
		logic        is_temp;
		logic [7:0]  byte_high;
		logic [1:0]  status;
		logic [7:0]  check_byte;
		logic [7:0]  crc;
		logic [30:0] product;
	} s2_t;

	typedef struct packed {
		logic signed [14:0] value;
		logic               crc_ok;
		logic [1:0]         status_bits;
		logic               heater_on;
		logic               battery_low;
	} result_t;

	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] c;
		c = crc ^ data;
		for (int b = 0; b < 8; b++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CrcPoly;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

FILE: rtl/htfd_in_if.sv
// Input channel carrying one received sensor frame per item.
interface htfd_in_if
	import htfd_pkg::*;
	();
	logic       valid;
	logic       ready;
	logic [1:0] cmd;
	logic [7:0] byte_high;
	logic [7:0] byte_low;
	logic [7:0] check_byte;

	modport source(output valid, output cmd, output byte_high, output byte_low,
		output check_byte, input ready);
	modport sink(input valid, input cmd, input byte_high, input byte_low,
		input check_byte, output ready);
endinterface

FILE: rtl/htfd_out_if.sv
// Output channel carrying one decoded result per item.
interface htfd_out_if
	import htfd_pkg::*;
	();
	logic               valid;
	logic               ready;
	logic signed [14:0] value;
	logic               crc_ok;
	logic [1:0]         status_bits;
	logic               heater_on;
	logic               battery_low;

	modport source(output valid, output value, output crc_ok, output status_bits,
		output heater_on, output battery_low, input ready);
	modport sink(input valid, input value, input crc_ok, input status_bits,
		input heater_on, input battery_low, output ready);
endinterface

FILE: rtl/humidity_temp_frame_decoder_top.sv
// Top level of the humidity and temperature frame decoder.
//
//   port     direction  content
//   frame    in         cmd, byte_high, byte_low, check_byte
//   result   out        value, crc_ok, status_bits, heater_on, battery_low
//
// Each item passes three register stages: first-byte CRC, second-byte CRC with
// the 15x16 scaling multiply, then offset, compare and the output register.
// One item can be accepted in every cycle while the result port does not stall.
// Reset clears only the stage valid bits; there is no other state.
// A stall at the result port holds each stage in place; a stage refills as soon
// as the stage after it moves on.
module humidity_temp_frame_decoder_top
	import htfd_pkg::*;
	(
	input  logic       clk,
	input  logic       arst_n,
	htfd_in_if.sink    frame,
	htfd_out_if.source result
);

	logic valid_s1;
	s1_t  data_s1;
	logic ready_s1;
	logic valid_s2;
	s2_t  data_s2;
	logic ready_s2;

	htfd_crc_stage u_crc (
		.clk        (clk),
		.arst_n     (arst_n),
		.frame      (frame),
		.ready_next (ready_s1),
		.valid_s1   (valid_s1),
		.data_s1    (data_s1)
	);

	htfd_scale_stage u_scale (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_s1   (valid_s1),
		.data_s1    (data_s1),
		.ready_in   (ready_s1),
		.ready_next (ready_s2),
		.valid_s2   (valid_s2),
		.data_s2    (data_s2)
	);

	htfd_finish_stage u_finish (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s2 (valid_s2),
		.data_s2  (data_s2),
		.ready_in (ready_s2),
		.result   (result)
	);

`ifndef SYNTHESIS
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		frame.valid && frame.ready |=> valid_s1)
		else $error("Accepted item did not reach the first stage.");

	a_s2_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !ready_s2 |=> valid_s2 && $stable(data_s2))
		else $error("Stalled second stage lost or changed its item.");

	a_flags_only_reg: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && (result.heater_on || result.battery_low)
			|-> result.status_bits == 2'b00 && result.value[14:8] == 7'd0)
		else $error("Register flags set on a measurement result.");

	a_reg_path: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && data_s2.is_reg |-> data_s2.status == 2'b00)
		else $error("Register read carries status bits.");
`endif

endmodule

FILE: rtl/htfd_crc_stage.sv
// First stage: captures the frame and runs the CRC over the first data byte.
module htfd_crc_stage
	import htfd_pkg::*;
	(
	input  logic     clk,
	input  logic     arst_n,
	htfd_in_if.sink  frame,
	input  logic     ready_next,
	output logic     valid_s1,
	output s1_t      data_s1
);

	logic load;

	assign frame.ready = !valid_s1 || ready_next;
	assign load = frame.valid && frame.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (frame.ready) begin
			valid_s1 <= frame.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_s1.is_reg     <= frame.cmd[CmdRegBit];
			data_s1.is_temp    <= (frame.cmd == CMD_TEMP);
			data_s1.byte_high  <= frame.byte_high;
			data_s1.byte_low   <= frame.byte_low;
			data_s1.check_byte <= frame.check_byte;
			data_s1.crc        <= crc8_byte(8'h00, frame.byte_high);
		end
	end

endmodule

FILE: rtl/htfd_scale_stage.sv
// Second stage: CRC over the second data byte (measurements only) and the scaling multiply.
module htfd_scale_stage
	import htfd_pkg::*;
	(
	input  logic clk,
	input  logic arst_n,
	input  logic valid_s1,
	input  s1_t  data_s1,
	output logic ready_in,
	input  logic ready_next,
	output logic valid_s2,
	output s2_t  data_s2
);

	logic        load;
	logic [15:0] raw;
	logic [15:0] masked;
	logic [14:0] scale;

	assign ready_in = !valid_s2 || ready_next;
	assign load = valid_s1 && ready_in;
	assign raw = {data_s1.byte_high, data_s1.byte_low};
	assign masked = {raw[15:2], 2'b00};
	assign scale = data_s1.is_temp ? TempScale : RhScale;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_in) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_s2.is_reg     <= data_s1.is_reg;
			data_s2.is_temp    <= data_s1.is_temp;
			data_s2.byte_high  <= data_s1.byte_high;
			data_s2.status     <= data_s1.is_reg ? 2'b00 : (raw[1:0] & StatusMask);
			data_s2.check_byte <= data_s1.check_byte;
			data_s2.crc        <= data_s1.is_reg ? data_s1.crc
				: crc8_byte(data_s1.crc, data_s1.byte_low);
			data_s2.product    <= {16'b0, scale} * {15'b0, masked};
		end
	end

endmodule

FILE: rtl/htfd_finish_stage.sv
// Third stage: offset, CRC compare and the output register of the result channel.
module htfd_finish_stage
	import htfd_pkg::*;
	(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      valid_s2,
	input  s2_t       data_s2,
	output logic      ready_in,
	htfd_out_if.source result
);

	logic               valid_s3;
	result_t            data_s3;
	logic               load;
	logic signed [15:0] scaled;
	logic signed [15:0] offset;
	logic signed [15:0] measured;

	assign ready_in = !valid_s3 || result.ready;
	assign load = valid_s2 && ready_in;
	assign scaled = {1'b0, data_s2.product[30:16]};
	assign offset = data_s2.is_temp ? TempOffset : RhOffset;
	assign measured = scaled - offset;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (ready_in) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_s3.value       <= data_s2.is_reg ? $signed({7'b0, data_s2.byte_high})
				: measured[14:0];
			data_s3.crc_ok      <= (data_s2.crc == data_s2.check_byte);
			data_s3.status_bits <= data_s2.status;
			data_s3.heater_on   <= data_s2.is_reg && data_s2.byte_high[HeaterBit];
			data_s3.battery_low <= data_s2.is_reg && data_s2.byte_high[EobBit];
		end
	end

	assign result.valid       = valid_s3;
	assign result.value       = data_s3.value;
	assign result.crc_ok      = data_s3.crc_ok;
	assign result.status_bits = data_s3.status_bits;
	assign result.heater_on   = data_s3.heater_on;
	assign result.battery_low = data_s3.battery_low;

endmodule

FILE: tb/sv/humidity_temp_frame_decoder_top_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the humidity and temperature frame decoder.
module humidity_temp_frame_decoder_top_tb;
	import htfd_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_CYCLES = 60;
	localparam logic [7:0] CRC8_POLY = 8'h31;
	localparam logic [31:0] RH_GAIN = 32'd12500;
	localparam logic [31:0] TEMP_GAIN = 32'd17572;
	localparam int RH_BASE = 600;
	localparam int TEMP_BASE = 4685;

	logic clk;
	logic arst_n;

	htfd_in_if  frame_if();
	htfd_out_if result_if();

	humidity_temp_frame_decoder_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.frame(frame_if),
		.result(result_if)
	);

	result_t pending_readings[$];
	bit idling = 1'b1;
	bit hold_request = 1'b0;
	int failures = 0;
	int readings_checked = 0;
	int cycle_count = 0;
	int kind_count[4];
	int bad_checksums = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
		logic fb;
		for (int i = 7; i >= 0; i--) begin
			fb = crc[7] ^ data[i];
			crc = {crc[6:0], 1'b0} ^ (fb ? CRC8_POLY : 8'h00);
		end
		return crc;
	endfunction

	function automatic bit is_register_read(input cmd_t cmd);
		return cmd == CMD_REG || cmd == CMD_SPARE;
	endfunction

	function automatic logic [7:0] frame_crc(input cmd_t cmd, input logic [7:0] hi,
		input logic [7:0] lo);
		logic [7:0] crc;
		crc = crc8_update(8'h00, hi);
		if (!is_register_read(cmd)) begin
			crc = crc8_update(crc, lo);
		end
		return crc;
	endfunction

	function automatic result_t decode_frame(input cmd_t cmd, input logic [7:0] hi,
		input logic [7:0] lo, input logic [7:0] chk);
		result_t r;
		logic [15:0] word;
		int reading;
		r = '0;
		word = {hi, lo};
		r.crc_ok = (frame_crc(cmd, hi, lo) == chk);
		if (is_register_read(cmd)) begin
			r.value = 15'(hi);
			r.heater_on = hi[HeaterBit];
			r.battery_low = hi[EobBit];
		end else begin
			r.status_bits = word[1:0];
			word[1:0] = 2'b00;
			if (cmd == CMD_HUMID) begin
				reading = int'((RH_GAIN * word) >> 16) - RH_BASE;
			end else begin
				reading = int'((TEMP_GAIN * word) >> 16) - TEMP_BASE;
			end
			r.value = 15'(reading);
		end
		return r;
	endfunction

	task automatic send_frame(input cmd_t cmd, input logic [7:0] hi, input logic [7:0] lo,
		input logic [7:0] chk);
		if (idling && $urandom_range(0, 3) == 0) begin
			frame_if.valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		frame_if.valid <= 1'b1;
		frame_if.cmd <= cmd;
		frame_if.byte_high <= hi;
		frame_if.byte_low <= lo;
		frame_if.check_byte <= chk;
		do @(posedge clk); while (!frame_if.ready);
		pending_readings.push_back(decode_frame(cmd, hi, lo, chk));
		kind_count[cmd]++;
		if (chk != frame_crc(cmd, hi, lo)) begin
			bad_checksums++;
		end
	endtask

	task automatic send_good_frame(input cmd_t cmd, input logic [7:0] hi, input logic [7:0] lo);
		send_frame(cmd, hi, lo, frame_crc(cmd, hi, lo));
	endtask

	task automatic send_random_frame;
		cmd_t cmd;
		logic [7:0] hi;
		logic [7:0] lo;
		logic [7:0] chk;
		cmd = cmd_t'($urandom_range(0, 3));
		hi = 8'($urandom);
		lo = 8'($urandom);
		if ($urandom_range(0, 3) != 0) begin
			chk = frame_crc(cmd, hi, lo);
		end else begin
			chk = 8'($urandom);
		end
		send_frame(cmd, hi, lo, chk);
	endtask

	task automatic wait_drain;
		frame_if.valid <= 1'b0;
		while (pending_readings.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Raw words at both ends of the range, with and without status bits.
	task automatic test_extremes;
		for (int k = 0; k < 2; k++) begin
			send_good_frame(cmd_t'(k), 8'h00, 8'h00);
			send_good_frame(cmd_t'(k), 8'hFF, 8'hFF);
			send_good_frame(cmd_t'(k), 8'hFF, 8'hFC);
			send_good_frame(cmd_t'(k), 8'h80, 8'h03);
		end
		send_good_frame(CMD_REG, 8'h00, 8'h00);
		send_good_frame(CMD_REG, 8'hFF, 8'hFF);
		send_good_frame(CMD_REG, 8'h04, 8'h00);
		send_good_frame(CMD_REG, 8'h40, 8'h00);
		send_good_frame(CMD_SPARE, 8'h44, 8'h5A);
		send_good_frame(CMD_SPARE, 8'hBB, 8'hA5);
	endtask

	// Corrupted checksums, and register reads whose unused byte must not matter.
	task automatic test_bad_checksum;
		cmd_t cmd;
		logic [7:0] hi;
		logic [7:0] lo;
		for (int k = 0; k < 4; k++) begin
			cmd = cmd_t'(k);
			hi = 8'($urandom);
			lo = 8'($urandom);
			send_frame(cmd, hi, lo, frame_crc(cmd, hi, lo) ^ 8'($urandom_range(1, 255)));
		end
		send_good_frame(CMD_REG, 8'h5C, 8'hFF);
		send_frame(CMD_REG, 8'h5C, 8'h00, crc8_update(crc8_update(8'h00, 8'h5C), 8'h00));
	endtask

	task automatic test_random_frames(input int count);
		repeat (count) send_random_frame();
	endtask

	// The receiver stalls for a long stretch while frames keep coming back to back.
	task automatic test_backpressure;
		idling = 1'b0;
		hold_request = 1'b1;
		repeat (24) send_random_frame();
		idling = 1'b1;
		wait_drain();
	endtask

	task automatic test_steady_stream(input int count);
		idling = 1'b0;
		repeat (count) send_random_frame();
		wait_drain();
	endtask

	initial begin
		int stall_left;
		stall_left = 0;
		result_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				stall_left = HOLD_CYCLES;
			end
			if (stall_left > 0) begin
				result_if.ready <= 1'b0;
				stall_left--;
			end else if (idling && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 7) - 1;
				result_if.ready <= 1'b0;
			end else begin
				result_if.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_if.valid && result_if.ready) begin
			if (pending_readings.size() == 0) begin
				$error("unexpected result item: value %0d", result_if.value);
				failures++;
			end else begin
				want = pending_readings.pop_front();
				readings_checked++;
				if (result_if.value !== want.value) begin
					$error("value: expected %0d, got %0d", want.value, result_if.value);
					failures++;
				end
				if (result_if.crc_ok !== want.crc_ok) begin
					$error("crc_ok: expected %0b, got %0b", want.crc_ok, result_if.crc_ok);
					failures++;
				end
				if (result_if.status_bits !== want.status_bits) begin
					$error("status_bits: expected %0d, got %0d", want.status_bits,
						result_if.status_bits);
					failures++;
				end
				if (result_if.heater_on !== want.heater_on) begin
					$error("heater_on: expected %0b, got %0b", want.heater_on,
						result_if.heater_on);
					failures++;
				end
				if (result_if.battery_low !== want.battery_low) begin
					$error("battery_low: expected %0b, got %0b", want.battery_low,
						result_if.battery_low);
					failures++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		frame_if.valid = 1'b0;
		frame_if.cmd = CMD_HUMID;
		frame_if.byte_high = 8'h00;
		frame_if.byte_low = 8'h00;
		frame_if.check_byte = 8'h00;
		for (int k = 0; k < 4; k++) begin
			kind_count[k] = 0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_extremes();
		wait_drain();
		test_bad_checksum();
		wait_drain();
		test_random_frames(600);
		wait_drain();
		test_backpressure();
		test_steady_stream(120);

		$display("Decoded %0d frames: %0d humidity, %0d temperature, %0d register reads.",
			readings_checked, kind_count[CMD_HUMID], kind_count[CMD_TEMP],
			kind_count[CMD_REG] + kind_count[CMD_SPARE]);
		$display("Frames with a corrupted checksum: %0d; long output stall exercised once.",
			bad_checksums);
		if (failures == 0 && pending_readings.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

FILE: files.f
rtl/htfd_pkg.sv
rtl/htfd_in_if.sv
rtl/htfd_out_if.sv
rtl/htfd_crc_stage.sv
rtl/htfd_scale_stage.sv
rtl/htfd_finish_stage.sv
rtl/humidity_temp_frame_decoder_top.sv
tb/sv/humidity_temp_frame_decoder_top_tb.sv
